### hw/rtl/mws_pkg.sv
// Package for the multimode waveshaper: widths, mode codes, pipeline stage
// record and the tanh lookup table built at elaboration.
// Used by multimode_waveshaper_top; depends on nothing else.
package mws_pkg;

  localparam int SW       = 24;          // sample width
  localparam int FRAC     = SW - 4;      // fraction bits
  localparam int TD       = 256;         // tanh table depth
  localparam int TDB      = $clog2(TD);
  localparam int MW       = SW + 2;      // driven magnitude, up to 4x range
  localparam int WW       = MW + 1;      // signed shaped value
  localparam int DW       = MW;          // softclip divisor width
  localparam int QW       = FRAC + 1;    // softclip quotient bits
  localparam int VW       = MW + FRAC;   // sqrt radicand width
  localparam int RW       = (VW + 1) / 2;
  localparam int NI       = RW;          // iteration stages
  localparam int SRW      = RW + 4;      // sqrt remainder width
  localparam int TW       = 31;          // tanh table entry width (Q30)
  localparam int FW       = FRAC + 3;    // tanh interpolation fraction bits
  localparam int GW       = 15;
  localparam int XW       = 13;
  localparam int CW       = 15;          // config data width
  localparam int IW       = 2;           // config index width

  localparam longint unsigned TANH_A = (64'd16 << 30) / TD;

  localparam logic [IW-1:0] REG_DRIVE = 2'd0;
  localparam logic [IW-1:0] REG_MIX   = 2'd1;
  localparam logic [IW-1:0] REG_MODE  = 2'd2;

  typedef enum logic [2:0] {
    MODE_FOLD     = 3'd0,
    MODE_TANH     = 3'd1,
    MODE_SOFTCLIP = 3'd2,
    MODE_HARDCLIP = 3'd3,
    MODE_SQRT     = 3'd4,
    MODE_RECTIFY  = 3'd5,
    MODE_CRUSH    = 3'd6
  } mode_t;

  typedef logic [TW-1:0] tanh_tab_t [0:TD];

  // Record carried through the iteration stages.
  typedef struct packed {
    logic                 valid;
    mode_t                mode;
    logic                 neg;
    logic signed [SW-1:0] dry;
    logic signed [WW-1:0] other;
    logic [DW-1:0]        den;
    logic [DW:0]          drem;
    logic [QW-1:0]        nlo;
    logic [QW-1:0]        quo;
    logic [VW-1:0]        sv;
    logic [SRW-1:0]       srem;
    logic [RW-1:0]        root;
    logic [TW-1:0]        tlo;
    logic [TW-1:0]        thi;
    logic [FW-1:0]        tf;
    logic [TW-1:0]        tprod;
    logic [QW-1:0]        tres;
  } it_t;

  // Shift-and-subtract division, used only while building the table.
  function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((n >> b) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // tanh(8i/TD) in Q30 from a truncated series for e^(-16/TD).
  function automatic tanh_tab_t build_tanh();
    tanh_tab_t         tab;
    longint unsigned   sum, term, e, den, q1;
    q1   = 64'd1 << 30;
    sum  = q1;
    term = q1;
    e    = q1;
    for (int k = 1; k <= 12; k++) begin
      term = udiv(term * TANH_A, longint'(k) << 30);
      if ((k & 1) == 1) sum = sum - term;
      else sum = sum + term;
    end
    for (int i = 0; i <= TD; i++) begin
      den    = q1 + e;
      tab[i] = TW'(udiv(((q1 - e) << 30) + (den >> 1), den));
      e      = (e * sum + (q1 >> 1)) >> 30;
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh();

endpackage

### hw/rtl/multimode_waveshaper_top.sv
// Multimode waveshaper top level: drive, seven shapers, wet/dry mix, saturation.
// Depends on mws_pkg for widths, mode codes, stage record and the tanh table.
//
//   channel | ports                          | transaction
//   --------+--------------------------------+------------------------------
//   input   | start, busy, sample_in         | start high while busy low
//   result  | done, sample_out               | done high for one cycle
//   config  | cfg_we, cfg_index, cfg_data    | cfg_we high, no wait
//
// One sample enters every cycle; its result is registered through stages 1 to 3,
// the iteration stages and final stages A to C. The depth is set by the
// bit-per-stage square root, beside which the softclip divider runs. Reset clears
// all valid bits and loads the register defaults; busy is high only during reset.
// Nothing stalls: the receiver takes every result in its cycle.
module multimode_waveshaper_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [mws_pkg::SW-1:0]   sample_in,
  output logic                            done,
  output logic signed [mws_pkg::SW-1:0]   sample_out,
  input  logic                            cfg_we,
  input  logic [mws_pkg::IW-1:0]          cfg_index,
  input  logic [mws_pkg::CW-1:0]          cfg_data
);
  import mws_pkg::*;

  localparam logic [MW-1:0] ONE_M  = MW'(1) << FRAC;
  localparam logic [GW-1:0] G_MAX  = GW'(16384);
  localparam logic [XW-1:0] X_MAX  = XW'(4096);

  logic [GW-1:0] drive_gain;
  logic [XW-1:0] wet_mix;
  logic [2:0]    shape_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_gain <= GW'(4096);
      wet_mix    <= XW'(4096);
      shape_mode <= MODE_FOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DRIVE: drive_gain <= cfg_data[GW-1:0];
        REG_MIX:   wet_mix    <= cfg_data[XW-1:0];
        REG_MODE:  shape_mode <= cfg_data[2:0];
        default:   ;
      endcase
    end
  end

  logic [GW-1:0] g_eff;
  logic [XW-1:0] x_eff;
  mode_t         mode_eff;
  assign g_eff    = (drive_gain > G_MAX) ? G_MAX : drive_gain;
  assign x_eff    = (wet_mix > X_MAX) ? X_MAX : wet_mix;
  assign mode_eff = (shape_mode == 3'd7) ? MODE_CRUSH : mode_t'(shape_mode);

  assign busy = rst;

  // Stage 1: magnitude of the dry sample.
  logic                 s1_valid, s1_neg;
  logic signed [SW-1:0] s1_dry;
  logic [SW-1:0]        s1_abs;
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= start && !busy;
    s1_dry <= sample_in;
    s1_neg <= sample_in[SW-1];
    s1_abs <= sample_in[SW-1] ? SW'(-sample_in) : SW'(sample_in);
  end

  // Stage 2: gain, rounded half away from zero on the magnitude.
  logic                 s2_valid, s2_neg;
  logic signed [SW-1:0] s2_dry;
  logic [MW-1:0]        s2_m;
  logic [SW+GW-1:0]     s1_prod;
  assign s1_prod = s1_abs * g_eff + (SW + GW)'(2048);
  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else s2_valid <= s1_valid;
    s2_dry <= s1_dry;
    s2_neg <= s1_neg;
    s2_m   <= MW'(s1_prod >> 12);
  end

  // Stage 3: closed-form shapers, table fetch and iteration set-up.
  logic signed [WW-1:0] sig, oth_mag, oth;
  logic [FRAC+1:0]      fold_t;
  logic signed [WW-1:0] fold_y;
  logic [MW+3:0]        crush_q;
  logic [MW-FRAC+8:0]   tidx;
  logic [VW:0]          numer;
  logic [DW-1:0]        den0;
  it_t                  init;
  it_t                  pipe [0:NI];

  always_comb begin
    sig     = s2_neg ? -WW'(s2_m) : WW'(s2_m);
    fold_t  = (FRAC + 2)'(sig + WW'(ONE_M));
    fold_y  = (fold_t < (FRAC + 2)'(2) << FRAC) ?
              WW'(fold_t) - WW'(ONE_M) : WW'(3) * WW'(ONE_M) - WW'(fold_t);
    crush_q = ((MW + 4)'(s2_m) * (MW + 4)'(8) + (MW + 4)'(ONE_M >> 1)) >> FRAC;
    unique case (mode_eff)
      MODE_HARDCLIP: oth_mag = WW'((s2_m > ONE_M) ? ONE_M : s2_m);
      MODE_RECTIFY:  oth_mag = WW'(s2_m);
      default:       oth_mag = WW'(crush_q << (FRAC - 3));
    endcase
    if (mode_eff == MODE_FOLD) oth = fold_y;
    else if (mode_eff == MODE_RECTIFY) oth = oth_mag;
    else oth = s2_neg ? -oth_mag : oth_mag;

    den0  = ONE_M + s2_m;
    numer = ((VW + 1)'(s2_m) << FRAC) + (VW + 1)'(den0 >> 1);
    tidx  = (MW - FRAC + 9)'(((MW + TDB)'(s2_m) << TDB) >> FW);

    init        = '0;
    init.valid  = s2_valid;
    init.mode   = mode_eff;
    init.neg    = s2_neg;
    init.dry    = s2_dry;
    init.other  = oth;
    init.den    = den0;
    init.drem   = (DW + 1)'(numer >> QW);
    init.nlo    = numer[QW-1:0];
    init.sv     = VW'(s2_m) << FRAC;
    if (tidx >= (MW - FRAC + 9)'(TD)) begin
      init.tlo = TW'(1) << 30;
      init.thi = TW'(1) << 30;
      init.tf  = '0;
    end else begin
      init.tlo = TANH_TAB[tidx[TDB-1:0]];
      init.thi = TANH_TAB[(TDB + 1)'(tidx[TDB-1:0]) + (TDB + 1)'(1)];
      init.tf  = FW'(s2_m << TDB);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pipe[0].valid <= 1'b0;
    else pipe[0].valid <= init.valid;
    pipe[0][$bits(it_t)-2:0] <= init[$bits(it_t)-2:0];
  end

  // Iteration stages: one root bit each, and one quotient bit in each of the first QW;
  // tanh interpolation rides along in the first two.
  for (genvar k = 0; k < NI; k++) begin : g_iter
    localparam int QB = (k < QW) ? QW - 1 - k : 0;
    it_t            nx;
    logic [DW+1:0]  dr;
    logic [SRW-1:0] sr, trial;
    always_comb begin
      nx = pipe[k];
      if (k < QW) begin
        dr = {pipe[k].drem, pipe[k].nlo[QB]};
        if (dr >= (DW + 2)'(pipe[k].den)) begin
          nx.drem = (DW + 1)'(dr - (DW + 2)'(pipe[k].den));
          nx.quo  = pipe[k].quo | (QW'(1) << QB);
        end else begin
          nx.drem = (DW + 1)'(dr);
        end
      end else begin
        dr = '0;
      end
      sr    = {pipe[k].srem[SRW-3:0], pipe[k].sv[VW-1-2*k -: 2]};
      trial = SRW'({pipe[k].root, 2'b01});
      if (sr >= trial) begin
        nx.srem = sr - trial;
        nx.root = {pipe[k].root[RW-2:0], 1'b1};
      end else begin
        nx.srem = sr;
        nx.root = {pipe[k].root[RW-2:0], 1'b0};
      end
      if (k == 0) begin
        nx.tprod = TW'(((2 * TW)'(pipe[k].thi - pipe[k].tlo) * (2 * TW)'(pipe[k].tf)) >> FW);
      end
      if (k == 1) begin
        nx.tres = QW'((pipe[k].tlo + pipe[k].tprod + (TW'(1) << (29 - FRAC)))
                      >> (30 - FRAC));
      end
    end
    always_ff @(posedge clk) begin
      if (rst) pipe[k+1].valid <= 1'b0;
      else pipe[k+1].valid <= nx.valid;
      pipe[k+1][$bits(it_t)-2:0] <= nx[$bits(it_t)-2:0];
    end
  end

  // Final stage A: select the shaped value and form the wet minus dry term.
  it_t                  fin;
  logic [RW:0]          root_r;
  logic [WW-1:0]        wmag;
  logic signed [WW-1:0] wet;
  logic signed [WW:0]   diff;
  logic                 f1_valid, f1_neg;
  logic signed [SW-1:0] f1_dry;
  logic [WW-1:0]        f1_mag;

  always_comb begin
    fin    = pipe[NI];
    root_r = (RW + 1)'(fin.root) + (RW + 1)'(fin.srem > SRW'(fin.root));
    unique case (fin.mode)
      MODE_TANH:     wmag = WW'(fin.tres);
      MODE_SOFTCLIP: wmag = WW'(fin.quo);
      MODE_SQRT:     wmag = WW'(root_r);
      default:       wmag = '0;
    endcase
    if (fin.mode == MODE_TANH || fin.mode == MODE_SOFTCLIP || fin.mode == MODE_SQRT)
      wet = fin.neg ? -wmag : wmag;
    else
      wet = fin.other;
    diff = (WW + 1)'(wet) - (WW + 1)'(fin.dry);
  end

  always_ff @(posedge clk) begin
    if (rst) f1_valid <= 1'b0;
    else f1_valid <= fin.valid;
    f1_dry <= fin.dry;
    f1_neg <= diff[WW];
    f1_mag <= diff[WW] ? WW'(-diff) : WW'(diff);
  end

  // Final stage B: mix scaling, rounded half away from zero.
  logic                 f2_valid, f2_neg;
  logic signed [SW-1:0] f2_dry;
  logic [WW-1:0]        f2_mag;
  logic [WW+XW-1:0]     f1_prod;
  assign f1_prod = f1_mag * x_eff + (WW + XW)'(2048);
  always_ff @(posedge clk) begin
    if (rst) f2_valid <= 1'b0;
    else f2_valid <= f1_valid;
    f2_dry <= f1_dry;
    f2_neg <= f1_neg;
    f2_mag <= WW'(f1_prod >> 12);
  end

  // Final stage C: add to the dry sample and saturate.
  localparam logic signed [WW+1:0] HI_S = (WW + 2)'((64'd1 << (SW - 1)) - 64'd1);
  localparam logic signed [WW+1:0] LO_S = -HI_S - (WW + 2)'(1);
  logic signed [WW+1:0] mixed;
  always_comb begin
    mixed = f2_neg ? (WW + 2)'(f2_dry) - (WW + 2)'(f2_mag)
                   : (WW + 2)'(f2_dry) + (WW + 2)'(f2_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= f2_valid;
    if (mixed > HI_S) sample_out <= HI_S[SW-1:0];
    else if (mixed < LO_S) sample_out <= LO_S[SW-1:0];
    else sample_out <= mixed[SW-1:0];
  end

endmodule

### tb/multimode_waveshaper_top_tb.sv
// Self-checking testbench for multimode_waveshaper_top: drives samples and register writes,
// predicts every output sample in a local model and compares it with the block's output.
// Depends on mws_pkg for widths, mode codes and register indexes.
module multimode_waveshaper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mws_pkg::*;

  localparam logic [IW-1:0] REG_SPARE = 2'd3;  // unmapped index, writes are dropped
  localparam longint ONE_Q = 64'sd1 <<< FRAC;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [SW-1:0] sample_in = '0;
  logic done;
  logic signed [SW-1:0] sample_out;
  logic cfg_we = 1'b0;
  logic [IW-1:0] cfg_index = REG_DRIVE;
  logic [CW-1:0] cfg_data = '0;

  multimode_waveshaper_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample_in(sample_in),
    .done(done), .sample_out(sample_out), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Local copy of the registers and the tanh lookup.
  logic [GW-1:0] gain_reg = 15'd4096;
  logic [XW-1:0] mix_reg = 13'd4096;
  logic [2:0] mode_reg = MODE_FOLD;
  longint unsigned tanh_lut [0:TD];

  logic signed [SW-1:0] expected_out_q [$];
  int errors = 0;
  bit no_gaps = 0;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void fill_tanh_lut();
    longint unsigned q1, a, sum, term, e, den;
    q1 = 64'd1 << 30;
    a = (64'd16 << 30) / TD;
    sum = q1;
    term = q1;
    e = q1;
    for (int k = 1; k <= 12; k++) begin
      term = (term * a) / (longint'(k) << 30);
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    for (int i = 0; i <= TD; i++) begin
      den = q1 + e;
      tanh_lut[i] = (((q1 - e) << 30) + den / 2) / den;
      e = (e * sum + (q1 >> 1)) >> 30;
    end
  endfunction

  function automatic longint unsigned round_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (v > r) r++;
    return r;
  endfunction

  function automatic longint tanh_of(longint unsigned m);
    longint unsigned p, idx, f, y;
    p = m * TD;
    idx = p >> FW;
    f = p & ((64'd1 << FW) - 1);
    if (idx >= TD) return ONE_Q;
    y = tanh_lut[idx] + (((tanh_lut[idx+1] - tanh_lut[idx]) * f) >> FW);
    return longint'((y + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
  endfunction

  function automatic logic signed [SW-1:0] shape_and_mix(logic signed [SW-1:0] s);
    longint dry, x, m, r, t, diff, mag, mixed, g, mx;
    logic [2:0] mode;
    bit neg;
    g = (gain_reg > 16384) ? 16384 : gain_reg;
    mx = (mix_reg > 4096) ? 4096 : mix_reg;
    mode = mode_reg;
    dry = s;
    neg = dry < 0;
    mag = (((neg ? -dry : dry) * g) + 2048) >>> 12;
    x = neg ? -mag : mag;
    neg = x < 0;
    m = neg ? -x : x;
    case (mode_t'(mode))
      MODE_FOLD: begin
        t = (x + ONE_Q) & (4 * ONE_Q - 1);
        r = (t < 2 * ONE_Q) ? t - ONE_Q : 3 * ONE_Q - t;
      end
      MODE_TANH: r = neg ? -tanh_of(m) : tanh_of(m);
      MODE_SOFTCLIP: begin
        r = (m * ONE_Q + (ONE_Q + m) / 2) / (ONE_Q + m);
        if (neg) r = -r;
      end
      MODE_HARDCLIP: begin
        r = (m > ONE_Q) ? ONE_Q : m;
        if (neg) r = -r;
      end
      MODE_SQRT: begin
        r = longint'(round_root(m * ONE_Q));
        if (neg) r = -r;
      end
      MODE_RECTIFY: r = m;
      default: begin
        // Crush covers mode seven as well.
        r = ((8 * m + (ONE_Q >>> 1)) >>> FRAC) <<< (FRAC - 3);
        if (neg) r = -r;
      end
    endcase
    diff = r - dry;
    neg = diff < 0;
    mag = (((neg ? -diff : diff) * mx) + 2048) >>> 12;
    mixed = dry + (neg ? -mag : mag);
    if (mixed > 64'sd8388607) mixed = 64'sd8388607;
    if (mixed < -64'sd8388608) mixed = -64'sd8388608;
    return mixed[SW-1:0];
  endfunction

  // One input transaction, followed by a random gap unless gaps are off.
  task automatic send_sample(logic signed [SW-1:0] v);
    int gap;
    start <= 1'b1;
    sample_in <= v;
    do @(posedge clk); while (busy);
    expected_out_q.push_back(shape_and_mix(v));
    if (no_gaps || $urandom_range(0, 9) < 6) gap = 0;
    else if ($urandom_range(0, 9) < 8) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 50);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops the sender and lets every outstanding result come back.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IW-1:0] idx, logic [CW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DRIVE: gain_reg = val[GW-1:0];
      REG_MIX: mix_reg = val[XW-1:0];
      REG_MODE: mode_reg = val[2:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic [CW-1:0] g, logic [CW-1:0] mx, logic [CW-1:0] md);
    wait_idle();
    write_reg(REG_DRIVE, g);
    write_reg(REG_MIX, mx);
    write_reg(REG_MODE, md);
  endtask

  function automatic logic signed [SW-1:0] random_sample();
    int kind;
    logic [31:0] u;
    kind = $urandom_range(0, 9);
    u = $urandom;
    case (kind)
      0: return u[0] ? 24'sh7FFFFF : 24'sh800000;
      1, 2: return $signed(u[SW-1:0]) >>> $urandom_range(0, 20);
      3: return $signed({u[6:0], 17'd0});          // steps of 1/8, near crush ties
      4: return $signed({u[7:0], 16'd0});
      default: return $signed(u[SW-1:0]);
    endcase
  endfunction

  task automatic test_directed_modes();
    logic signed [SW-1:0] pts [0:6];
    pts = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'sh100000, -24'sh100000,
            24'sh010000, -24'sh030000};
    for (int md = 0; md <= 7; md++) begin
      set_config(15'd4096, 15'd4096, CW'(md));
      foreach (pts[i]) send_sample(pts[i]);
    end
  endtask

  task automatic test_config_extremes();
    set_config(15'd0, 15'd4096, CW'(MODE_SQRT));
    send_sample(24'sh123456);
    send_sample(-24'sh123456);
    set_config(15'd16384, 15'd0, CW'(MODE_TANH));
    send_sample(24'sh7FFFFF);
    send_sample(-24'sh000001);
    set_config(15'h7FFF, 15'h7FFF, CW'(MODE_TANH));
    send_sample(24'sh7FFFFF);
    send_sample(24'sh200000);
    set_config(15'd16385, 15'd4097, CW'(MODE_FOLD));
    write_reg(REG_SPARE, 15'd0);
    send_sample(24'sh300000);
    send_sample(-24'sh7FFFFF);
    set_config(15'd8192, 15'd2048, CW'(MODE_HARDCLIP));
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
  endtask

  task automatic test_random_phases();
    logic [CW-1:0] g, mx;
    for (int ph = 0; ph < 14; ph++) begin
      case ($urandom_range(0, 4))
        0: g = CW'($urandom_range(0, 32767));
        1: g = ($urandom_range(0, 1) != 0) ? 15'd0 : 15'd16384;
        default: g = CW'($urandom_range(0, 16384));
      endcase
      mx = ($urandom_range(0, 3) == 0) ? CW'($urandom_range(0, 32767)) :
           ($urandom_range(0, 2) == 0 ? 15'd4096 : CW'($urandom_range(0, 4096)));
      set_config(g, mx, CW'($urandom_range(0, 7)));
      no_gaps = (ph % 4 == 1);
      repeat (50) send_sample(random_sample());
      no_gaps = 0;
    end
  endtask

  // Result checker: every done pulse must match the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_out_q.size() == 0) begin
        report_mismatch("unexpected result", sample_out, 0);
      end else begin
        logic signed [SW-1:0] want;
        want = expected_out_q.pop_front();
        if (sample_out !== want) report_mismatch("sample_out", sample_out, want);
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || done || cfg_we || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("multimode_waveshaper_top_tb failed");
      $finish;
    end
  end

  initial begin
    fill_tanh_lut();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // Reset defaults first: unity drive, fully wet, fold.
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(24'sh180000);
    test_directed_modes();
    test_config_extremes();
    test_random_phases();
    wait_idle();
    if (errors == 0) $display("multimode_waveshaper_top_tb passed");
    else $display("multimode_waveshaper_top_tb failed");
    $finish;
  end

endmodule
